[sv/salc_pkg.sv]
package salc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        KIND_HIT     = 3'd0,
        KIND_MISS    = 3'd1,
        KIND_EVICT   = 3'd2,
        KIND_CACHED  = 3'd3,
        KIND_REJECT  = 3'd4,
        KIND_REFRESH = 3'd5
    } t_kind;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_RECEIVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic        opcode;
        logic [31:0] event_time;
        logic [15:0] object_id;
        logic [23:0] object_size;
    } t_in;

    typedef struct packed {
        t_kind       result_kind;
        logic [15:0] result_id;
        logic [23:0] result_size;
        logic [23:0] occupied_total;
        logic        last_result;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] time_stamp;
        logic [23:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[sv/salc_ram.sv]
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/size_aware_lru_cache_unit.sv]
// Byte-budgeted least-recently-used object cache.
// The input channel carries one request or receive per transfer; the output
// channel carries one or more results per item, the final one marked by
// last_result. The configuration channel writes the capacity limit and is
// always ready; the user must write it only while the unit is idle (not enforced).
// Entries live in a single-port-write, registered-read table of ENTRIES words.
// Every item starts with a scan that reads the whole table, one entry per
// cycle, to find a matching id and the oldest entry, then a decision step
// that issues a result. Each eviction issues one result and rescans the
// table. The next item is accepted once the last result has been loaded
// into the output register.
// A synchronous active-low reset clears all valid bits, the occupancy and the
// capacity limit; table contents need no clearing.
// When the receiver stalls, the result stays in the output register and the
// unit waits in its decision step until the register frees up.
module size_aware_lru_cache_unit
    import salc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES);

    t_state              r_state, n_state;
    t_in                 r_in, n_in;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [23:0]         r_occ, n_occ;
    logic [23:0]         r_cap;
    logic                r_match, n_match;
    logic [IDX_W-1:0]    r_match_idx, n_match_idx;
    t_entry              r_match_ent, n_match_ent;
    logic                r_vic, n_vic;
    logic [IDX_W-1:0]    r_vic_idx, n_vic_idx;
    t_entry              r_vic_ent, n_vic_ent;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    logic [IDX_W-1:0]    cmp_idx;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic                out_free;
    logic                over;
    logic [23:0]         occ_sub;

    salc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_cnt[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign cmp_idx  = IDX_W'(r_cnt - CNT_W'(1));
    assign out_free = !r_out_valid || i_out_ready;
    assign over     = ({1'b0, r_occ} + {1'b0, r_in.object_size}) > {1'b0, r_cap};
    assign occ_sub  = (r_occ >= r_vic_ent.size) ? r_occ - r_vic_ent.size : 24'd0;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_cnt       = r_cnt;
        n_valid     = r_valid;
        n_occ       = r_occ;
        n_match     = r_match;
        n_match_idx = r_match_idx;
        n_match_ent = r_match_ent;
        n_vic       = r_vic;
        n_vic_idx   = r_vic_idx;
        n_vic_ent   = r_vic_ent;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_cnt   = '0;
                    n_match = 1'b0;
                    n_vic   = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt != '0 && r_valid[cmp_idx]) begin
                    if (ram_rdata.id == r_in.object_id) begin
                        n_match     = 1'b1;
                        n_match_idx = cmp_idx;
                        n_match_ent = ram_rdata;
                    end
                    if (!r_vic || ram_rdata.time_stamp < r_vic_ent.time_stamp ||
                        (ram_rdata.time_stamp == r_vic_ent.time_stamp &&
                         ram_rdata.id < r_vic_ent.id)) begin
                        n_vic     = 1'b1;
                        n_vic_idx = cmp_idx;
                        n_vic_ent = ram_rdata;
                    end
                end
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.result_id       = r_in.object_id;
                    n_out.last_result     = 1'b1;
                    n_out.occupied_total  = r_occ;
                    n_state               = ST_IDLE;
                    if (r_in.opcode == OP_REQUEST || r_match) begin
                        if (r_match) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_match_idx;
                            ram_wdata = '{id: r_match_ent.id, time_stamp: r_in.event_time,
                                          size: r_match_ent.size};
                            n_out.result_size = r_match_ent.size;
                        end else begin
                            n_out.result_size = '0;
                        end
                        if (r_in.opcode == OP_REQUEST) begin
                            n_out.result_kind = r_match ? KIND_HIT : KIND_MISS;
                        end else if (r_in.object_size > r_cap) begin
                            ram_we            = 1'b0;
                            n_out.result_kind = KIND_REJECT;
                            n_out.result_size = r_in.object_size;
                        end else begin
                            n_out.result_kind = KIND_REFRESH;
                        end
                    end else if (r_in.object_size > r_cap) begin
                        n_out.result_kind = KIND_REJECT;
                        n_out.result_size = r_in.object_size;
                    end else if ((!over && free_found) || !r_vic) begin
                        ram_we               = 1'b1;
                        ram_waddr            = free_idx;
                        ram_wdata            = '{id: r_in.object_id,
                                                 time_stamp: r_in.event_time,
                                                 size: r_in.object_size};
                        n_valid[free_idx]    = 1'b1;
                        n_occ                = r_occ + r_in.object_size;
                        n_out.result_kind    = KIND_CACHED;
                        n_out.result_size    = r_in.object_size;
                        n_out.occupied_total = n_occ;
                    end else begin
                        n_valid[r_vic_idx]   = 1'b0;
                        n_occ                = occ_sub;
                        n_out.result_kind    = KIND_EVICT;
                        n_out.result_id      = r_vic_ent.id;
                        n_out.result_size    = r_vic_ent.size;
                        n_out.occupied_total = occ_sub;
                        n_out.last_result    = 1'b0;
                        n_cnt                = '0;
                        n_match              = 1'b0;
                        n_vic                = 1'b0;
                        n_state              = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_match     <= 1'b0;
            r_vic       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_match     <= n_match;
            r_vic       <= n_vic;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_match_idx <= n_match_idx;
        r_match_ent <= n_match_ent;
        r_vic_idx   <= n_vic_idx;
        r_vic_ent   <= n_vic_ent;
        r_out       <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[test/size_aware_lru_cache_unit_tb.sv]
module size_aware_lru_cache_unit_tb;
    import salc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data;

    size_aware_lru_cache_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int CYCLE_LIMIT = 1500000;

    t_in  pending_items[$];
    t_out expected_results[$];

    logic [23:0] cache_capacity;
    logic        slot_valid[ENTRIES];
    logic [15:0] slot_id[ENTRIES];
    logic [31:0] slot_time[ENTRIES];
    logic [23:0] slot_size[ENTRIES];
    logic [23:0] cache_occupied;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_cycles;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned eviction_count;
    int unsigned capacity_writes;
    logic [31:0] clock_ticks;
    logic        in_accepted;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_out make_result(t_kind kind, logic [15:0] id, logic [23:0] size,
                                         logic last);
        t_out r;
        r.result_kind    = kind;
        r.result_id      = id;
        r.result_size    = size;
        r.occupied_total = cache_occupied;
        r.last_result    = last;
        return r;
    endfunction

    function automatic int find_slot(logic [15:0] id);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && slot_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int find_oldest();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (best < 0 || slot_time[i] < slot_time[best] ||
                (slot_time[i] == slot_time[best] && slot_id[i] < slot_id[best]))) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void predict_cache(t_in item);
        int slot;
        int victim;
        slot = find_slot(item.object_id);
        if (item.opcode == OP_REQUEST) begin
            if (slot >= 0) begin
                slot_time[slot] = item.event_time;
                expected_results.push_back(make_result(KIND_HIT, item.object_id,
                                                       slot_size[slot], 1'b1));
            end else begin
                expected_results.push_back(make_result(KIND_MISS, item.object_id, '0, 1'b1));
            end
            return;
        end
        if (item.object_size > cache_capacity) begin
            expected_results.push_back(make_result(KIND_REJECT, item.object_id,
                                                   item.object_size, 1'b1));
            return;
        end
        if (slot >= 0) begin
            slot_time[slot] = item.event_time;
            expected_results.push_back(make_result(KIND_REFRESH, item.object_id,
                                                   slot_size[slot], 1'b1));
            return;
        end
        forever begin
            if ({1'b0, cache_occupied} + {1'b0, item.object_size} <= {1'b0, cache_capacity}
                && find_free_slot() >= 0) begin
                break;
            end
            victim = find_oldest();
            if (victim < 0) begin
                break;
            end
            slot_valid[victim] = 1'b0;
            cache_occupied = (cache_occupied >= slot_size[victim]) ?
                             cache_occupied - slot_size[victim] : '0;
            eviction_count++;
            expected_results.push_back(make_result(KIND_EVICT, slot_id[victim],
                                                   slot_size[victim], 1'b0));
        end
        slot = find_free_slot();
        if (slot < 0) begin
            slot = 0;
        end
        slot_valid[slot] = 1'b1;
        slot_id[slot]    = item.object_id;
        slot_time[slot]  = item.event_time;
        slot_size[slot]  = item.object_size;
        cache_occupied   = cache_occupied + item.object_size;
        expected_results.push_back(make_result(KIND_CACHED, item.object_id,
                                               item.object_size, 1'b1));
    endfunction

    function automatic t_in make_item(t_op op, logic [31:0] ts, logic [15:0] id,
                                      logic [23:0] size);
        t_in item;
        item.opcode      = op;
        item.event_time  = ts;
        item.object_id   = id;
        item.object_size = size;
        return item;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ENTRIES * 20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [23:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        cache_capacity = value;
        capacity_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int unsigned count, logic [15:0] id_span, logic [23:0] size_span);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            clock_ticks = clock_ticks + $urandom_range(0, 3);
            if (pick < 5) begin
                pending_items.push_back(make_item(t_op'($urandom_range(0, 1)), $urandom,
                                                  16'($urandom), 24'($urandom)));
            end else if (pick < 45) begin
                pending_items.push_back(make_item(OP_REQUEST, clock_ticks,
                                                  16'($urandom_range(0, id_span)),
                                                  24'($urandom)));
            end else begin
                pending_items.push_back(make_item(OP_RECEIVE, clock_ticks,
                                                  16'($urandom_range(0, id_span)),
                                                  24'($urandom_range(0, size_span))));
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepted) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in       <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        in_accepted <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_cache(i_in);
            items_sent++;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready     <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.result_kind !== want.result_kind
                    || o_out.result_id !== want.result_id
                    || o_out.result_size !== want.result_size
                    || o_out.occupied_total !== want.occupied_total
                    || o_out.last_result !== want.last_result) begin
                    $display("%0t: result mismatch, expected %h, actual %h",
                             $time, want, o_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in            = '0;
        i_out_ready     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        in_accepted     = 1'b0;
        send_idle_pct   = 13;
        recv_idle_pct   = 70;
        hold_off_cycles = 0;
        cycle_count     = 0;
        error_count     = 0;
        items_sent      = 0;
        results_seen    = 0;
        eviction_count  = 0;
        capacity_writes = 0;
        clock_ticks     = 32'd100;
        cache_capacity  = '0;
        cache_occupied  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_id[i]    = '0;
            slot_time[i]  = '0;
            slot_size[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // With zero capacity only empty objects fit, and the full table forces evictions.
        pending_items.push_back(make_item(OP_RECEIVE, 32'd5, 16'd7, 24'd1));
        pending_items.push_back(make_item(OP_RECEIVE, 32'd5, 16'd7, 24'd0));
        pending_items.push_back(make_item(OP_REQUEST, 32'd6, 16'd7, 24'hFFFFFF));
        for (int i = 0; i < 17; i++) begin
            pending_items.push_back(make_item(OP_RECEIVE, 32'd9, 16'(100 - i), 24'd0));
        end
        wait_drained();

        write_capacity(24'hFFFFFF);
        pending_items.push_back(make_item(OP_RECEIVE, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF));
        pending_items.push_back(make_item(OP_REQUEST, 32'h0, 16'hFFFF, 24'd0));
        pending_items.push_back(make_item(OP_RECEIVE, 32'h1, 16'hFFFF, 24'd3));
        pending_items.push_back(make_item(OP_REQUEST, 32'h2, 16'h0000, 24'd0));
        pending_items.push_back(make_item(OP_RECEIVE, 32'h3, 16'h0000, 24'd1));
        wait_drained();

        // Lowering the capacity leaves entries in place until the next new object.
        write_capacity(24'd40);
        pending_items.push_back(make_item(OP_RECEIVE, 32'h4, 16'h1234, 24'd41));
        pending_items.push_back(make_item(OP_RECEIVE, 32'h5, 16'h1234, 24'd40));
        wait_drained();

        write_capacity(24'd1000);
        queue_random(150, 16'd40, 24'd300);
        hold_off_cycles = 600;
        wait_drained();

        send_idle_pct = 70;
        recv_idle_pct = 13;
        write_capacity(24'd200);
        queue_random(150, 16'd24, 24'd120);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(24'hFFFFFF);
        queue_random(150, 16'hFFFF, 24'hFFFFFF);
        wait_drained();

        $display("Covered %0d items, %0d results with %0d evictions, %0d capacity writes.",
                 items_sent, results_seen, eviction_count, capacity_writes);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
